// ===== rtl/csmp_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the CRT shadow mask pixel block.
package csmp_pkg;

   typedef enum logic [1:0] {
      MASK_GRILLE   = 2'd0,
      MASK_SLOT     = 2'd1,
      MASK_TRIAD    = 2'd2,
      MASK_SLOT_ALT = 2'd3
   } mask_type_type;

   typedef enum logic [2:0] {
      REG_MASK_TYPE       = 3'd0,
      REG_CELL_SIZE       = 3'd1,
      REG_IMAGE_HEIGHT    = 3'd2,
      REG_MASK_STRENGTH   = 3'd3,
      REG_BRIGHTNESS_GAIN = 3'd4,
      REG_MIX_AMOUNT      = 3'd5
   } reg_index_type;

   localparam int unsigned Latency = 8;

   localparam logic [1:0]  ResetMaskType   = 2'd0;
   localparam logic [3:0]  ResetCellSize   = 4'd3;
   localparam logic [13:0] ResetHeight     = 14'd1080;
   localparam logic [16:0] ResetStrength   = 17'd32768;
   localparam logic [15:0] ResetGain       = 16'd19661;
   localparam logic [16:0] ResetMix        = 17'd65536;
   localparam logic [16:0] UnitQ16         = 17'd65536;

   // floor(2^16 / size), for the reciprocal divide of a cell coordinate
   function automatic logic [16:0] recip(input logic [3:0] size);
      logic [16:0] r;
      case (size)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21845;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13107;
         4'd6:    r = 17'd10922;
         4'd7:    r = 17'd9362;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7281;
         4'd10:   r = 17'd6553;
         4'd11:   r = 17'd5957;
         4'd12:   r = 17'd5461;
         4'd13:   r = 17'd5041;
         4'd14:   r = 17'd4681;
         4'd15:   r = 17'd4369;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // sum base-4 digits, since 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [14:0] val);
      logic [15:0] ext;
      logic [4:0]  acc;
      logic [3:0]  acc2;
      ext = {1'b0, val};
      acc = 5'd0;
      for (int i = 0; i < 8; i++) begin
         acc = acc + 5'(ext[2*i +: 2]);
      end
      acc2 = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[4]);
      if (acc2 >= 4'd6) begin
         acc2 = acc2 - 4'd6;
      end else if (acc2 >= 4'd3) begin
         acc2 = acc2 - 4'd3;
      end
      return acc2[1:0];
   endfunction

endpackage

// ===== rtl/crt_shadow_mask_pixel.sv =====
// CRT shadow mask pixel filter: eight-stage pipeline from pixel in to masked pixel out.
//
// Usage: pulse start with a pixel on the req_ ports; the item is taken at a rising
// edge where start is high and busy is low. busy is high only while reset is held,
// so one pixel may be taken on every clock.
// Each result shows on the rsp_ ports for exactly one cycle with rsp_valid high,
// once its item has passed through the pipeline, in the order taken. Throughput is
// one pixel per clock; the stages are cell divide (reciprocal multiply and
// correction), mask select, channel by mask, by gain, rounding, blend partial
// products and the final sum with saturation.
// The receiver cannot stall the output; nothing is held back.
// The csr_ port writes register csr_index with csr_wdata on any edge with csr_we
// high and reset low: 0 mask type, 1 cell size, 2 image height, 3 strength, 4 gain, 5 mix.
// Write registers only while no pixel is in flight.
// Synchronous reset restores register defaults and empties the pipeline.
module crt_shadow_mask_pixel
   import csmp_pkg::*;
#(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [12:0] req_column,
   input  logic [12:0] req_row_from_bottom,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic [15:0] req_alpha_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   output logic [15:0] rsp_alpha_out,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   localparam logic [15:0] FullScale = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

   logic [1:0]  cfg_type_ff;
   logic [3:0]  cfg_size_ff;
   logic [13:0] cfg_height_ff;
   logic [16:0] cfg_strength_ff;
   logic [15:0] cfg_gain_ff;
   logic [16:0] cfg_mix_ff;

   logic [3:0]  sz;
   logic [16:0] recip_val;
   logic [16:0] s_sat;
   logic [16:0] x_sat;
   logic [16:0] lo_val;
   logic [17:0] dim_r;
   logic [16:0] one_minus_x;
   logic [16:0] lit_dim;
   logic [34:0] lo_prod;
   logic [16:0] lo_dim;
   mask_type_type mtype;

   logic [7:0] vld_ff;

   logic [12:0]      col_a_ff;
   logic [13:0]      ty_a_ff;
   logic [29:0]      pc_a_ff;
   logic [30:0]      pt_a_ff;
   logic [2:0][15:0] ch_a_ff;
   logic [15:0]      alpha_a_ff;
   logic [13:0]      ty_a_in;
   logic [29:0]      pc_a_in;
   logic [30:0]      pt_a_in;

   logic [12:0]      ccol_b_ff;
   logic [13:0]      crow_b_ff;
   logic [2:0][15:0] ch_b_ff;
   logic [15:0]      alpha_b_ff;
   logic [12:0]      ccol_b_in;
   logic [13:0]      crow_b_in;
   logic [12:0]      qc0;
   logic [12:0]      rc;
   logic [13:0]      qt0;
   logic [13:0]      rt;

   logic [2:0][16:0] m_c_ff;
   logic [2:0][15:0] ch_c_ff;
   logic [15:0]      alpha_c_ff;
   logic [2:0][16:0] m_c_in;
   logic [1:0]       idx;
   logic             dim;

   logic [2:0][32:0] p_d_ff;
   logic [2:0][15:0] ch_d_ff;
   logic [15:0]      alpha_d_ff;
   logic [2:0][32:0] p_d_in;

   logic [2:0][48:0] q_e_ff;
   logic [2:0][15:0] ch_e_ff;
   logic [15:0]      alpha_e_ff;
   logic [2:0][48:0] q_e_in;

   logic [2:0][34:0] o_f_ff;
   logic [2:0][15:0] ch_f_ff;
   logic [15:0]      alpha_f_ff;
   logic [2:0][34:0] o_f_in;

   logic [2:0][32:0] base_g_ff;
   logic [2:0][33:0] pphi_g_ff;
   logic [2:0][34:0] pplo_g_ff;
   logic [15:0]      alpha_g_ff;
   logic [2:0][32:0] base_g_in;
   logic [2:0][33:0] pphi_g_in;
   logic [2:0][34:0] pplo_g_in;

   logic [2:0][15:0] out_ff;
   logic [15:0]      alpha_out_ff;
   logic [2:0][15:0] out_in;
   logic [15:0]      alpha_out_in;
   logic [2:0][52:0] acc;
   logic [2:0][20:0] acc_hi;

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_type_ff     <= ResetMaskType;
         cfg_size_ff     <= ResetCellSize;
         cfg_height_ff   <= ResetHeight;
         cfg_strength_ff <= ResetStrength;
         cfg_gain_ff     <= ResetGain;
         cfg_mix_ff      <= ResetMix;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_MASK_TYPE:       cfg_type_ff     <= csr_wdata[1:0];
            REG_CELL_SIZE:       cfg_size_ff     <= csr_wdata[3:0];
            REG_IMAGE_HEIGHT:    cfg_height_ff   <= csr_wdata[13:0];
            REG_MASK_STRENGTH:   cfg_strength_ff <= csr_wdata;
            REG_BRIGHTNESS_GAIN: cfg_gain_ff     <= csr_wdata[15:0];
            REG_MIX_AMOUNT:      cfg_mix_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mtype       = mask_type_type'(cfg_type_ff);
      sz          = (cfg_size_ff == 4'd0) ? 4'd1 : cfg_size_ff;
      recip_val   = recip(sz);
      s_sat       = (cfg_strength_ff > UnitQ16) ? UnitQ16 : cfg_strength_ff;
      x_sat       = (cfg_mix_ff > UnitQ16) ? UnitQ16 : cfg_mix_ff;
      lo_val      = UnitQ16 - s_sat;
      dim_r       = 18'd131072 - {1'b0, s_sat};
      one_minus_x = UnitQ16 - x_sat;
      lit_dim     = 17'((dim_r + 18'd1) >> 1);
      lo_prod     = 35'(lo_val) * 35'(dim_r);
      lo_dim      = 17'((36'(lo_prod) + 36'd65536) >> 17);
   end

   // stage A: top-down row and reciprocal products
   always_comb begin
      ty_a_in = ({1'b0, req_row_from_bottom} < cfg_height_ff)
              ? 14'(cfg_height_ff - 14'd1 - {1'b0, req_row_from_bottom}) : 14'd0;
      pc_a_in = 30'(req_column) * 30'(recip_val);
      pt_a_in = 31'(ty_a_in) * 31'(recip_val);
   end

   // stage B: correct quotient estimates by at most one
   always_comb begin
      qc0 = pc_a_ff[28:16];
      rc  = col_a_ff - 13'(17'(qc0) * 17'(sz));
      ccol_b_in = (rc >= 13'(sz)) ? qc0 + 13'd1 : qc0;
      qt0 = pt_a_ff[29:16];
      rt  = ty_a_ff - 14'(18'(qt0) * 18'(sz));
      crow_b_in = (rt >= 14'(sz)) ? qt0 + 14'd1 : qt0;
   end

   // stage C: stripe index and row dimming
   always_comb begin
      if (mtype == MASK_TRIAD) begin
         idx = mod3(15'(ccol_b_ff) + 15'(crow_b_ff));
      end else begin
         idx = mod3(15'(ccol_b_ff));
      end
      dim = (mtype == MASK_SLOT || mtype == MASK_SLOT_ALT)
         && !(crow_b_ff[0] ^ ccol_b_ff[0]);
      for (int k = 0; k < 3; k++) begin
         if (idx == 2'(k)) begin
            m_c_in[k] = dim ? lit_dim : UnitQ16;
         end else begin
            m_c_in[k] = dim ? lo_dim : lo_val;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p_d_in[k]    = 33'(ch_c_ff[k]) * 33'(m_c_ff[k]);
         q_e_in[k]    = 49'(p_d_ff[k]) * 49'(cfg_gain_ff);
         o_f_in[k]    = 35'((50'(q_e_ff[k]) + 50'd8192) >> 14);
         base_g_in[k] = 33'(ch_f_ff[k]) * 33'(one_minus_x);
         pplo_g_in[k] = 35'(o_f_ff[k][17:0]) * 35'(x_sat);
         pphi_g_in[k] = 34'(o_f_ff[k][34:18]) * 34'(x_sat);
         acc[k] = 53'({base_g_ff[k], 16'h0000}) + 53'({pphi_g_ff[k], 18'h00000})
                + 53'(pplo_g_ff[k]) + 53'h0_0000_8000_0000;
         acc_hi[k] = acc[k][52:32];
         out_in[k] = (acc_hi[k] > 21'(FullScale)) ? FullScale : acc_hi[k][15:0];
      end
      alpha_out_in = (alpha_g_ff > FullScale) ? FullScale : alpha_g_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      col_a_ff   <= req_column;
      ty_a_ff    <= ty_a_in;
      pc_a_ff    <= pc_a_in;
      pt_a_ff    <= pt_a_in;
      ch_a_ff    <= {req_blue_in, req_green_in, req_red_in};
      alpha_a_ff <= req_alpha_in;

      ccol_b_ff  <= ccol_b_in;
      crow_b_ff  <= crow_b_in;
      ch_b_ff    <= ch_a_ff;
      alpha_b_ff <= alpha_a_ff;

      m_c_ff     <= m_c_in;
      ch_c_ff    <= ch_b_ff;
      alpha_c_ff <= alpha_b_ff;

      p_d_ff     <= p_d_in;
      ch_d_ff    <= ch_c_ff;
      alpha_d_ff <= alpha_c_ff;

      q_e_ff     <= q_e_in;
      ch_e_ff    <= ch_d_ff;
      alpha_e_ff <= alpha_d_ff;

      o_f_ff     <= o_f_in;
      ch_f_ff    <= ch_e_ff;
      alpha_f_ff <= alpha_e_ff;

      base_g_ff  <= base_g_in;
      pphi_g_ff  <= pphi_g_in;
      pplo_g_ff  <= pplo_g_in;
      alpha_g_ff <= alpha_f_ff;

      out_ff       <= out_in;
      alpha_out_ff <= alpha_out_in;
   end

   assign rsp_valid     = vld_ff[7];
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];
   assign rsp_alpha_out = alpha_out_ff;

endmodule

// ===== rtl/csmp_checker.sv =====
// Port-level checks for the CRT shadow mask pixel block, bound to the top level.
module csmp_checker
   import csmp_pkg::*;
#(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_alpha_in,
   input logic        rsp_valid,
   input logic [15:0] rsp_red_out,
   input logic [15:0] rsp_green_out,
   input logic [15:0] rsp_blue_out,
   input logic [15:0] rsp_alpha_out
);

   localparam logic [15:0] FullScale = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

   property p_latency;
      @(posedge clock) disable iff (reset)
         rsp_valid == $past(start && !busy, Latency);
   endproperty
   a_latency: assert property (p_latency) else $error("result strobe out of step with items");

   property p_alpha;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_alpha_out == (($past(req_alpha_in, Latency) > FullScale)
            ? FullScale : $past(req_alpha_in, Latency));
   endproperty
   a_alpha: assert property (p_alpha) else $error("alpha not carried with its item");

   property p_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_red_out <= FullScale) && (rsp_green_out <= FullScale)
            && (rsp_blue_out <= FullScale);
   endproperty
   a_range: assert property (p_range) else $error("channel above full scale");

   property p_reset_empty;
      @(posedge clock) $fell(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result left over from reset");

endmodule

bind crt_shadow_mask_pixel csmp_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_csmp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_alpha_in  (req_alpha_in),
   .rsp_valid     (rsp_valid),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_alpha_out (rsp_alpha_out)
);

// ===== sim/tb_crt_shadow_mask_pixel.sv =====
// Self-checking testbench for the CRT shadow mask pixel filter: predicts each masked pixel.
module tb_crt_shadow_mask_pixel;
   import csmp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ChannelBits = 16;
   localparam logic [63:0] FullScale = (64'd1 << ChannelBits) - 64'd1;
   localparam int unsigned StallLimit = 1000;

   typedef struct packed {
      logic [12:0] column;
      logic [12:0] row_from_bottom;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } pixel_in_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } pixel_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [12:0] req_column = '0;
   logic [12:0] req_row_from_bottom = '0;
   logic [15:0] req_red_in = '0;
   logic [15:0] req_green_in = '0;
   logic [15:0] req_blue_in = '0;
   logic [15:0] req_alpha_in = '0;
   logic        rsp_valid;
   logic [15:0] rsp_red_out;
   logic [15:0] rsp_green_out;
   logic [15:0] rsp_blue_out;
   logic [15:0] rsp_alpha_out;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   mask_type_type cfg_mask = mask_type_type'(ResetMaskType);
   logic [3:0]    cfg_size = ResetCellSize;
   logic [13:0]   cfg_height = ResetHeight;
   logic [16:0]   cfg_strength = ResetStrength;
   logic [15:0]   cfg_gain = ResetGain;
   logic [16:0]   cfg_mix = ResetMix;

   pixel_in_type   pending_pixels[$];
   pixel_out_type  expected_pixels[$];
   pixel_in_type   driven_pixel = '0;
   int unsigned idle_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;

   crt_shadow_mask_pixel #(
      .CHANNEL_BITS(ChannelBits)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_column(req_column),
      .req_row_from_bottom(req_row_from_bottom),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .req_alpha_in(req_alpha_in),
      .rsp_valid(rsp_valid),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_alpha_out(rsp_alpha_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pixel_out_type mask_pixel(input pixel_in_type px);
      logic [63:0] sz, s, x, lo, ty, crow, ccol, stagger, dim;
      logic [63:0] o16, acc;
      logic [63:0] m [3];
      logic [63:0] ch [3];
      logic [15:0] shaded [3];
      logic [1:0]  stripe;
      pixel_out_type  res;
      sz = (cfg_size == 4'd0) ? 64'd1 : 64'(cfg_size);
      s = (cfg_strength > UnitQ16) ? 64'(UnitQ16) : 64'(cfg_strength);
      x = (cfg_mix > UnitQ16) ? 64'(UnitQ16) : 64'(cfg_mix);
      lo = 64'd65536 - s;
      ty = (64'(px.row_from_bottom) < 64'(cfg_height)) ?
           64'(cfg_height) - 64'd1 - 64'(px.row_from_bottom) : 64'd0;
      crow = ty / sz;
      ccol = 64'(px.column) / sz;
      stripe = (cfg_mask == MASK_TRIAD) ? 2'((ccol + crow) % 3) : 2'(ccol % 3);
      for (int k = 0; k < 3; k++) begin
         m[k] = (stripe == k) ? 64'd65536 : lo;
      end
      if (cfg_mask == MASK_SLOT || cfg_mask == MASK_SLOT_ALT) begin
         stagger = ccol[0] ? sz : 64'd0;
         if ((((ty + stagger) / sz) % 2) == 0) begin
            dim = 64'd131072 - s;
            for (int k = 0; k < 3; k++) begin
               m[k] = (m[k] * dim + 64'd65536) >> 17;
            end
         end
      end
      ch[0] = 64'(px.red);
      ch[1] = 64'(px.green);
      ch[2] = 64'(px.blue);
      for (int k = 0; k < 3; k++) begin
         o16 = (ch[k] * m[k] * 64'(cfg_gain) + 64'd8192) >> 14;
         acc = ((ch[k] << 16) * (64'd65536 - x)) + o16 * x + 64'h8000_0000;
         acc = acc >> 32;
         shaded[k] = (acc > FullScale) ? 16'(FullScale) : 16'(acc);
      end
      res.red = shaded[0];
      res.green = shaded[1];
      res.blue = shaded[2];
      res.alpha = (64'(px.alpha) > FullScale) ? 16'(FullScale) : px.alpha;
      return res;
   endfunction

   function automatic logic [15:0] rand_channel();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic pixel_in_type rand_pixel();
      pixel_in_type   px;
      int unsigned rows;
      rows = (cfg_height > 14'd8192) ? 8192 : int'(cfg_height);
      px.column = ($urandom_range(3) == 0) ? 13'($urandom_range(63))
                                           : 13'($urandom_range(8191));
      if (rows == 0 || $urandom_range(3) == 0) begin
         px.row_from_bottom = 13'($urandom_range(8191));
      end else begin
         px.row_from_bottom = 13'($urandom_range(rows - 1));
      end
      px.red = rand_channel();
      px.green = rand_channel();
      px.blue = rand_channel();
      px.alpha = rand_channel();
      return px;
   endfunction

   function automatic pixel_in_type make_pixel(input logic [12:0] col, input logic [12:0] row,
                                               input logic [15:0] r, input logic [15:0] g,
                                               input logic [15:0] b, input logic [15:0] a);
      pixel_in_type px;
      px.column = col;
      px.row_from_bottom = row;
      px.red = r;
      px.green = g;
      px.blue = b;
      px.alpha = a;
      return px;
   endfunction

   task automatic add_pending(input pixel_in_type px);
      pending_pixels.insert(pending_pixels.size(), px);
   endtask

   always @(posedge clock) begin
      if (start && !busy) begin
         expected_pixels.insert(expected_pixels.size(), mask_pixel(driven_pixel));
      end
      if (!(start && busy)) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
            driven_pixel <= pending_pixels[0];
            req_column <= pending_pixels[0].column;
            req_row_from_bottom <= pending_pixels[0].row_from_bottom;
            req_red_in <= pending_pixels[0].red;
            req_green_in <= pending_pixels[0].green;
            req_blue_in <= pending_pixels[0].blue;
            req_alpha_in <= pending_pixels[0].alpha;
            pending_pixels.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t %s expected %h actual %h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_out_type exp_px;
      if (rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t unexpected item expected none actual %h %h %h %h", $time,
                     rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
            mismatch_count++;
         end else begin
            exp_px = expected_pixels.pop_front();
            check_field("red_out", exp_px.red, rsp_red_out);
            check_field("green_out", exp_px.green, rsp_green_out);
            check_field("blue_out", exp_px.blue, rsp_blue_out);
            check_field("alpha_out", exp_px.alpha, rsp_alpha_out);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic set_reg(input reg_index_type idx, input logic [16:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_MASK_TYPE:       cfg_mask = mask_type_type'(val[1:0]);
         REG_CELL_SIZE:       cfg_size = val[3:0];
         REG_IMAGE_HEIGHT:    cfg_height = val[13:0];
         REG_MASK_STRENGTH:   cfg_strength = val;
         REG_BRIGHTNESS_GAIN: cfg_gain = val[15:0];
         REG_MIX_AMOUNT:      cfg_mix = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input mask_type_type mt, input logic [3:0] size,
                                 input logic [13:0] height, input logic [16:0] strength,
                                 input logic [15:0] gain, input logic [16:0] mix);
      set_reg(REG_MASK_TYPE, 17'(mt));
      set_reg(REG_CELL_SIZE, 17'(size));
      set_reg(REG_IMAGE_HEIGHT, 17'(height));
      set_reg(REG_MASK_STRENGTH, strength);
      set_reg(REG_BRIGHTNESS_GAIN, 17'(gain));
      set_reg(REG_MIX_AMOUNT, mix);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (pending_pixels.size() != 0 || start || expected_pixels.size() != 0);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) add_pending(rand_pixel());
   endtask

   // rows at the top edge, at the height and beyond it
   task automatic queue_edges();
      logic [12:0] top_row;
      logic [12:0] past_row;
      top_row = (cfg_height == 14'd0) ? 13'd0 :
                (cfg_height > 14'd8192) ? 13'd8191 : 13'(cfg_height - 14'd1);
      past_row = (cfg_height > 14'd8191) ? 13'd8191 : 13'(cfg_height);
      add_pending(make_pixel(13'd0, top_row, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_pending(make_pixel(13'd8191, past_row, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000));
      add_pending(make_pixel(13'($urandom_range(31)), 13'd8191, 16'hFFFF, 16'h0000,
                             16'hFFFF, 16'h5A5A));
   endtask

   initial begin
      int unsigned phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      add_pending(make_pixel(13'd0, 13'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      add_pending(make_pixel(13'd8191, 13'd8191, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_pending(make_pixel(13'd0, 13'd1079, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234));
      add_pending(make_pixel(13'd3, 13'd1078, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000));
      add_pending(make_pixel(13'd6, 13'd1080, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF));
      add_pending(make_pixel(13'd1, 13'd5, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
      add_pending(make_pixel(13'd4095, 13'd540, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      add_pending(make_pixel(13'd4096, 13'd1, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
      add_pending(make_pixel(13'd12, 13'd2, 16'hFFFE, 16'h7FFF, 16'h8001, 16'h8000));
      add_pending(make_pixel(13'd8190, 13'd1000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF));
      wait_drained();

      for (phase = 0; phase < 13; phase++) begin
         case (phase)
            0: apply_settings(MASK_GRILLE, 4'd1, 14'd8192, 17'd65536, 16'd32768, 17'd65536);
            1: apply_settings(MASK_SLOT, 4'd8, 14'd1, 17'd0, 16'd8192, 17'd0);
            2: apply_settings(MASK_TRIAD, 4'd0, 14'd0, 17'd131071, 16'd65535, 17'd131071);
            3: apply_settings(MASK_SLOT_ALT, 4'd15, 14'd16383, 17'd70000, 16'd0, 17'd100000);
            default: apply_settings(mask_type_type'($urandom_range(3)),
                                    ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                                               4'($urandom_range(1, 8)),
                                    ($urandom_range(7) == 0) ? 14'($urandom_range(16383)) :
                                                               14'($urandom_range(1, 8192)),
                                    ($urandom_range(7) == 0) ? 17'($urandom_range(131071)) :
                                                               17'($urandom_range(65536)),
                                    ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) :
                                                               16'($urandom_range(8192, 32768)),
                                    ($urandom_range(7) == 0) ? 17'($urandom_range(131071)) :
                                                               17'($urandom_range(65536)));
         endcase
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 64;
            default: idle_pct = 9;
         endcase
         if (phase < 4) begin
            queue_edges();
         end
         queue_random(100);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== crt_shadow_mask_pixel.f =====
rtl/csmp_pkg.sv
rtl/crt_shadow_mask_pixel.sv
rtl/csmp_checker.sv
sim/tb_crt_shadow_mask_pixel.sv
